/* design/tspq_pkg.sv */
// Shared constants, codes and types for the TSP QUBO cost evaluator.
`timescale 1ns / 1ps

package tspq_pkg;

    // Default geometry
    localparam int CITIES_DEF     = 3;
    localparam int DIST_WIDTH_DEF = 16;

    // Result format
    localparam int          COST_W   = 24;
    localparam logic [23:0] COST_MAX = 24'hFF_FFFF;

    // Input operation codes (carried in tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Configuration map
    localparam int         PADDR_W         = 3;
    localparam logic       REG_PENALTY_SEL = 1'b0;   // paddr[2] for register 0
    localparam logic [7:0] PENALTY_RESET   = 8'd30;

    // Sequencer to accumulate unit control
    typedef struct packed {
        logic clear;
        logic add_dist;
        logic add_pen;
    } t_acc_ctl;

endpackage

/* design/tspq_dist_mem.sv */
// Distance matrix store: one write port, one registered read port.
`timescale 1ns / 1ps

module tspq_dist_mem #(
    parameter int DEPTH = tspq_pkg::CITIES_DEF * tspq_pkg::CITIES_DEF,
    parameter int DW    = tspq_pkg::DIST_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tspq_acc.sv */
// Shared saturating accumulate unit for distance and penalty terms.
`timescale 1ns / 1ps

module tspq_acc #(
    parameter int DIST_WIDTH = tspq_pkg::DIST_WIDTH_DEF,
    parameter int SQ_W       = 3
) (
    input  logic                            i_clk,
    input  tspq_pkg::t_acc_ctl              i_ctl,
    input  logic [DIST_WIDTH-1:0]           i_dist,
    input  logic [7:0]                      i_weight,
    input  logic [SQ_W-1:0]                 i_diff_sq,
    output logic [tspq_pkg::COST_W-1:0]     o_acc
);

    localparam int PT_W = 16 + SQ_W;
    localparam int TW   = (DIST_WIDTH > PT_W) ? DIST_WIDTH : PT_W;
    localparam int SW   = ((TW > tspq_pkg::COST_W) ? TW : tspq_pkg::COST_W) + 1;

    logic [tspq_pkg::COST_W-1:0] r_acc;
    logic [tspq_pkg::COST_W-1:0] n_acc;
    logic [8+SQ_W-1:0]           prod;
    logic [PT_W-1:0]             pen_term;
    logic [TW-1:0]               term;
    logic [SW-1:0]               sum;

    // Pick the term: stored distance or weight times squared deviation, scaled to Q(8+SQ_W).8 (Q11.8 when SQ_W is 3)
    always_comb begin
        prod     = (8+SQ_W)'(i_weight) * (8+SQ_W)'(i_diff_sq);
        pen_term = {prod, 8'b0};
        term     = i_ctl.add_dist ? TW'(i_dist) : TW'(pen_term);
        sum      = SW'(r_acc) + SW'(term);
    end

    // Add with saturation; all terms are non-negative so clamping each step is exact
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.add_dist || i_ctl.add_pen) begin
            if (sum > SW'(tspq_pkg::COST_MAX)) begin
                n_acc = tspq_pkg::COST_MAX;
            end else begin
                n_acc = sum[tspq_pkg::COST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

/* design/tspq_seq.sv */
// Sequencer: walks city pairs and steps, then row and column penalties.
`timescale 1ns / 1ps

module tspq_seq #(
    parameter int CITIES = tspq_pkg::CITIES_DEF,
    parameter int CELLS  = CITIES * CITIES,
    parameter int AW     = $clog2(CELLS),
    parameter int SQ_W   = $clog2((CITIES - 1) * (CITIES - 1) + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CELLS-1:0]    i_bits,
    input  logic                i_out_free,
    output logic                o_idle,
    output logic                o_done,
    output logic [AW-1:0]       o_raddr,
    output tspq_pkg::t_acc_ctl  o_ctl,
    output logic [SQ_W-1:0]     o_diff_sq
);

    localparam int CW   = $clog2(CITIES);
    localparam int PW   = $clog2(2 * CITIES);
    localparam int CNTW = $clog2(CITIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIST  = 3'd1;
    localparam logic [2:0] S_PEN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CELLS-1:0]    r_bits, n_bits;
    logic [CW-1:0]       r_i, n_i, r_j, n_j, r_t, n_t;
    logic [AW-1:0]       r_addr, n_addr;
    logic [PW-1:0]       r_p, n_p;
    tspq_pkg::t_acc_ctl  r_ctl, n_ctl;
    logic [SQ_W-1:0]     r_diff_sq, n_diff_sq;

    logic [CW-1:0]       nt;
    logic [AW-1:0]       pos_a, pos_b;
    logic                hit;
    logic [CITIES-1:0]   sel;
    logic [CNTW-1:0]     cnt;
    logic [CNTW-1:0]     diff;
    logic [SQ_W-1:0]     diff_sq;
    logic                last_t, last_j, last_i, last_p;

    // Occupancy test for the current city pair at step t and the next step
    always_comb begin
        last_t = (r_t == CW'(CITIES - 1));
        last_j = (r_j == CW'(CITIES - 1));
        last_i = (r_i == CW'(CITIES - 1));
        last_p = (r_p == PW'(2 * CITIES - 1));
        nt     = last_t ? '0 : r_t + 1'b1;
        pos_a  = AW'(r_t) * AW'(CITIES) + AW'(r_i);
        pos_b  = AW'(nt) * AW'(CITIES) + AW'(r_j);
        hit    = r_bits[pos_a] & r_bits[pos_b];
    end

    // Count one row (city over steps) or one column (step over cities)
    always_comb begin
        for (int k = 0; k < CITIES; k++) begin
            if (r_p < PW'(CITIES)) begin
                sel[k] = r_bits[AW'(k) * AW'(CITIES) + AW'(r_p)];
            end else begin
                sel[k] = r_bits[AW'(r_p - PW'(CITIES)) * AW'(CITIES) + AW'(k)];
            end
        end
        cnt = '0;
        for (int k = 0; k < CITIES; k++) begin
            cnt = cnt + CNTW'(sel[k]);
        end
        diff    = (cnt == '0) ? CNTW'(1) : cnt - 1'b1;
        diff_sq = SQ_W'(SQ_W'(diff) * SQ_W'(diff));
    end

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_bits    = r_bits;
        n_i       = r_i;
        n_j       = r_j;
        n_t       = r_t;
        n_addr    = r_addr;
        n_p       = r_p;
        n_ctl     = '0;
        n_diff_sq = r_diff_sq;
        o_done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_bits      = i_bits;
                    n_i         = '0;
                    n_j         = '0;
                    n_t         = '0;
                    n_addr      = '0;
                    n_ctl.clear = 1'b1;
                    n_state     = S_DIST;
                end
            end
            S_DIST: begin
                // Issue the read now; the add follows with the registered data
                n_ctl.add_dist = hit;
                n_t            = nt;
                if (last_t) begin
                    n_addr = r_addr + 1'b1;
                    n_j    = last_j ? '0 : r_j + 1'b1;
                    if (last_j) begin
                        n_i = last_i ? '0 : r_i + 1'b1;
                        if (last_i) begin
                            n_p     = '0;
                            n_state = S_PEN;
                        end
                    end
                end
            end
            S_PEN: begin
                n_ctl.add_pen = 1'b1;
                n_diff_sq     = diff_sq;
                n_p           = r_p + 1'b1;
                if (last_p) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand the total over once the output register has room
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctl   <= '0;
        end else begin
            r_state <= n_state;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits    <= n_bits;
        r_i       <= n_i;
        r_j       <= n_j;
        r_t       <= n_t;
        r_addr    <= n_addr;
        r_p       <= n_p;
        r_diff_sq <= n_diff_sq;
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_raddr   = r_addr;
    assign o_ctl     = r_ctl;
    assign o_diff_sq = r_diff_sq;

endmodule

/* design/tsp_qubo_cost_eval.sv */
// Load beats leave the block ready for the next beat.
// An evaluate beat is worked through by one shared saturating adder taking one distance or
// penalty term a cycle; the block takes no beat until its result has gone to the output register,
// and a result still waiting in the output register holds the next one back.
// Synchronous active-low reset clears control and sets penalty_weight to 30; the distance
// matrix is not cleared and holds no valid data until loaded.
`timescale 1ns / 1ps

module tsp_qubo_cost_eval #(
    parameter int CITIES     = tspq_pkg::CITIES_DEF,
    parameter int DIST_WIDTH = tspq_pkg::DIST_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // from_city, to_city, distance_value, assignment_bits, pad
    input  logic [0:0]                      s_tuser,  // operation
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tspq_pkg::COST_W-1:0]     m_tdata,  // cost
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tspq_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CELLS = CITIES * CITIES;
    localparam int AW    = $clog2(CELLS);
    localparam int SQ_W  = $clog2((CITIES - 1) * (CITIES - 1) + 1);
    localparam int IW    = 6;  // wide enough for from_city*CITIES + to_city

    logic [1:0]                     from_city;
    logic [1:0]                     to_city;
    logic [15:0]                    distance_value;
    logic [8:0]                     assignment_bits;
    logic                           accept;
    logic                           wr_ok;
    logic [IW-1:0]                  wr_idx;
    logic [31:0]                    dist32;
    logic [31:0]                    bits32;

    logic [7:0]                     r_penalty_weight;
    logic                           r_m_valid;
    logic [tspq_pkg::COST_W-1:0]    r_m_data;

    logic                           seq_idle;
    logic                           seq_done;
    logic [AW-1:0]                  raddr;
    tspq_pkg::t_acc_ctl             acc_ctl;
    logic [SQ_W-1:0]                diff_sq;
    logic [DIST_WIDTH-1:0]          rd_data;
    logic [tspq_pkg::COST_W-1:0]    acc_value;
    logic                           out_free;

    // Unpack the input beat
    assign from_city       = s_tdata[1:0];
    assign to_city         = s_tdata[3:2];
    assign distance_value  = s_tdata[19:4];
    assign assignment_bits = s_tdata[28:20];

    assign s_tready = seq_idle;
    assign accept   = s_tvalid && seq_idle;

    // Drop loads that name a city outside the matrix
    always_comb begin
        wr_ok  = (3'(from_city) < 3'(CITIES)) && (3'(to_city) < 3'(CITIES));
        wr_idx = IW'(from_city) * IW'(CITIES) + IW'(to_city);
        dist32 = 32'(distance_value);
        bits32 = 32'(assignment_bits);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty_weight <= tspq_pkg::PENALTY_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == tspq_pkg::REG_PENALTY_SEL) begin
            r_penalty_weight <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tspq_pkg::REG_PENALTY_SEL) ? 32'(r_penalty_weight) : '0;

    tspq_dist_mem #(
        .DEPTH (CELLS),
        .DW    (DIST_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (accept && s_tuser[0] == tspq_pkg::OP_LOAD && wr_ok),
        .i_waddr (AW'(wr_idx)),
        .i_wdata (dist32[DIST_WIDTH-1:0]),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    tspq_seq #(
        .CITIES (CITIES),
        .CELLS  (CELLS),
        .AW     (AW),
        .SQ_W   (SQ_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && s_tuser[0] == tspq_pkg::OP_EVAL),
        .i_bits     (bits32[CELLS-1:0]),
        .i_out_free (out_free),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_raddr    (raddr),
        .o_ctl      (acc_ctl),
        .o_diff_sq  (diff_sq)
    );

    tspq_acc #(
        .DIST_WIDTH (DIST_WIDTH),
        .SQ_W       (SQ_W)
    ) u_acc (
        .i_clk     (i_clk),
        .i_ctl     (acc_ctl),
        .i_dist    (rd_data),
        .i_weight  (r_penalty_weight),
        .i_diff_sq (diff_sq),
        .o_acc     (acc_value)
    );

    // Output register: hold the result until the beat is taken
    assign out_free = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (seq_done) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_m_data <= acc_value;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

/* design/tspq_checker.sv */
// Port-level checks for the TSP QUBO cost evaluator, bound to the top level.
`timescale 1ns / 1ps

module tspq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [0:0]                   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tspq_pkg::COST_W-1:0]  m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An evaluate beat keeps the input closed on the next cycle
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[0] == tspq_pkg::OP_EVAL |=> !s_tready)
        else $error("input still open after an evaluate beat");

    // A load beat leaves the input open
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[0] == tspq_pkg::OP_LOAD |=> s_tready)
        else $error("input closed after a load beat");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind tsp_qubo_cost_eval tspq_checker u_tspq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
